@@ rtl/cbs_pkg.sv @@
package cbs_pkg;

    localparam int COORD_BITS = 24;
    localparam int MAX_DEPTH  = 4;
    localparam int DEPTH_W    = 3;
    localparam int LVL_W      = $clog2(MAX_DEPTH + 1);
    localparam int SLOT_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int IN_W       = 8 * COORD_BITS;
    localparam int IN_BYTES   = (IN_W + 7) / 8;
    localparam int OUT_W      = 4 * COORD_BITS;
    localparam int OUT_BYTES  = (OUT_W + 7) / 8;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [LVL_W-1:0]             level_t;
    typedef logic [SLOT_W-1:0]            slot_t;

    typedef struct packed {
        coord_t y;
        coord_t x;
    } point_t;

    typedef struct packed {
        point_t d;
        point_t c;
        point_t b;
        point_t a;
    } curve_t;

    // right half of a split, waiting for its turn
    typedef struct packed {
        point_t d;
        point_t c;
        point_t b;
    } half_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic  load;
        logic  split;
        logic  emit;
        logic  pop;
        logic  last;
        slot_t slot;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    // floor((a + b) / 2) on the exact sum
    function automatic coord_t mid(coord_t a, coord_t b);
        logic signed [COORD_BITS:0] s;
        s = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
        return s[COORD_BITS:1];
    endfunction

    function automatic point_t mid_pt(point_t p, point_t q);
        point_t r;
        r.x = mid(p.x, q.x);
        r.y = mid(p.y, q.y);
        return r;
    endfunction

endpackage

@@ rtl/cbs_ctrl.sv @@
module cbs_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cbs_pkg::DEPTH_W-1:0]       depth,
    input  cbs_pkg::status_t                  status,
    output cbs_pkg::cmd_t                     cmd
);

    cbs_pkg::state_t state_reg, state_next;
    cbs_pkg::level_t level_reg, level_next;
    logic [1:0]                   cnt_reg, cnt_next;
    logic [cbs_pkg::MAX_DEPTH-1:0] pend_reg, pend_next;

    cbs_pkg::slot_t low_slot;
    cbs_pkg::slot_t push_slot;
    cbs_pkg::level_t level_m1;
    logic           accept;
    logic           seg_done;

    localparam logic [1:0] SEG_LAST = 2'd2;

    assign accept    = s_tvalid && s_tready;
    assign level_m1  = level_reg - cbs_pkg::level_t'(1);
    assign push_slot = level_m1[cbs_pkg::SLOT_W-1:0];
    assign seg_done  = (state_reg == cbs_pkg::ST_EMIT) && status.out_free &&
                       (cnt_reg == SEG_LAST);

    // most recently pushed half sits at the lowest pending slot
    always_comb begin
        low_slot = '0;
        for (int i = cbs_pkg::MAX_DEPTH - 1; i >= 0; i--) begin
            if (pend_reg[i]) begin
                low_slot = cbs_pkg::slot_t'(i);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cbs_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = (depth == '0) ? cbs_pkg::ST_EMIT : cbs_pkg::ST_SPLIT;
                end
            end
            cbs_pkg::ST_SPLIT: begin
                if (level_reg == cbs_pkg::level_t'(1)) begin
                    state_next = cbs_pkg::ST_EMIT;
                end
            end
            cbs_pkg::ST_EMIT: begin
                if (seg_done) begin
                    if (pend_reg == '0) begin
                        state_next = cbs_pkg::ST_IDLE;
                    end else if (low_slot != '0) begin
                        state_next = cbs_pkg::ST_SPLIT;
                    end
                end
            end
            default: state_next = cbs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd        = '0;
        s_tready   = 1'b0;
        level_next = level_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        case (state_reg)
            cbs_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    cmd.load   = 1'b1;
                    level_next = cbs_pkg::level_t'(depth);
                    cnt_next   = '0;
                    pend_next  = '0;
                end
            end
            cbs_pkg::ST_SPLIT: begin
                cmd.split             = 1'b1;
                cmd.slot              = push_slot;
                pend_next[push_slot]  = 1'b1;
                level_next            = level_m1;
            end
            cbs_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    cnt_next = cnt_reg + 2'd1;
                    if (cnt_reg == SEG_LAST) begin
                        cnt_next = '0;
                        if (pend_reg == '0) begin
                            cmd.last = 1'b1;
                        end else begin
                            cmd.pop             = 1'b1;
                            cmd.slot            = low_slot;
                            pend_next[low_slot] = 1'b0;
                            level_next          = cbs_pkg::level_t'(low_slot);
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cbs_pkg::ST_IDLE;
            level_reg <= '0;
            cnt_reg   <= '0;
            pend_reg  <= '0;
        end else begin
            state_reg <= state_next;
            level_reg <= level_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

@@ rtl/cbs_datapath.sv @@
module cbs_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cbs_pkg::curve_t      curve,
    input  cbs_pkg::cmd_t        cmd,
    output cbs_pkg::status_t     status,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output cbs_pkg::point_t      out_from,
    output cbs_pkg::point_t      out_to,
    output logic                 out_last
);

    cbs_pkg::point_t pen_reg, b_reg, c_reg, d_reg;
    cbs_pkg::half_t  stack_reg [cbs_pkg::MAX_DEPTH];

    cbs_pkg::point_t ab, bc, cd, abc, bcd, m;
    cbs_pkg::point_t from_reg, to_reg;
    logic            last_reg;
    logic            valid_reg;

    assign ab  = cbs_pkg::mid_pt(pen_reg, b_reg);
    assign bc  = cbs_pkg::mid_pt(b_reg, c_reg);
    assign cd  = cbs_pkg::mid_pt(c_reg, d_reg);
    assign abc = cbs_pkg::mid_pt(ab, bc);
    assign bcd = cbs_pkg::mid_pt(bc, cd);
    assign m   = cbs_pkg::mid_pt(abc, bcd);

    assign status.out_free = !valid_reg || m_tready;

    assign m_tvalid = valid_reg;
    assign out_from = from_reg;
    assign out_to   = to_reg;
    assign out_last = last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pen_reg <= curve.a;
            b_reg   <= curve.b;
            c_reg   <= curve.c;
            d_reg   <= curve.d;
        end else if (cmd.split) begin
            // pen stays: left half starts where the pen is
            b_reg <= ab;
            c_reg <= abc;
            d_reg <= m;
            stack_reg[cmd.slot] <= '{d: d_reg, c: cd, b: bcd};
        end else if (cmd.emit) begin
            pen_reg <= b_reg;
            if (cmd.pop) begin
                b_reg <= stack_reg[cmd.slot].b;
                c_reg <= stack_reg[cmd.slot].c;
                d_reg <= stack_reg[cmd.slot].d;
            end else begin
                b_reg <= c_reg;
                c_reg <= d_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            from_reg <= pen_reg;
            to_reg   <= b_reg;
            last_reg <= cmd.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

endmodule

@@ rtl/cubic_bezier_subdivider_top.sv @@
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata: four control points of one curve
// m_        out  m_tvalid/m_tready  m_tdata: one line segment, m_tlast on last
// cfg_      in   cfg_wr_en          cfg_wr_data: subdivision depth (0..4)
//
// A curve at depth n is accepted, then split 2^n - 1 times and emitted as
// 3 * 2^n segments. Each split is done by the midpoint unit; each segment
// passes through the output register.
// A stall on m_tready holds the segment sequencer; s_tready is high only
// between curves. Reset clears control state and sets the depth to 4.
module cubic_bezier_subdivider_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // start_x, start_y, ctrl_one_x, ctrl_one_y, ctrl_two_x, ctrl_two_y,
    // end_x, end_y
    input  logic [8*cbs_pkg::IN_BYTES-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // from_x, from_y, to_x, to_y
    output logic [8*cbs_pkg::OUT_BYTES-1:0]   m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic [cbs_pkg::DEPTH_W-1:0]       cfg_wr_data
);

    logic [cbs_pkg::DEPTH_W-1:0] depth_reg;
    logic [cbs_pkg::DEPTH_W-1:0] depth_sat;
    cbs_pkg::curve_t             curve;
    cbs_pkg::cmd_t               cmd;
    cbs_pkg::status_t            status;
    cbs_pkg::point_t             out_from, out_to;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= cbs_pkg::DEPTH_W'(cbs_pkg::MAX_DEPTH);
        end else if (cfg_wr_en) begin
            depth_reg <= cfg_wr_data;
        end
    end

    assign depth_sat = (depth_reg > cbs_pkg::DEPTH_W'(cbs_pkg::MAX_DEPTH)) ?
                       cbs_pkg::DEPTH_W'(cbs_pkg::MAX_DEPTH) : depth_reg;

    assign curve.a.x = s_tdata[0*cbs_pkg::COORD_BITS +: cbs_pkg::COORD_BITS];
    assign curve.a.y = s_tdata[1*cbs_pkg::COORD_BITS +: cbs_pkg::COORD_BITS];
    assign curve.b.x = s_tdata[2*cbs_pkg::COORD_BITS +: cbs_pkg::COORD_BITS];
    assign curve.b.y = s_tdata[3*cbs_pkg::COORD_BITS +: cbs_pkg::COORD_BITS];
    assign curve.c.x = s_tdata[4*cbs_pkg::COORD_BITS +: cbs_pkg::COORD_BITS];
    assign curve.c.y = s_tdata[5*cbs_pkg::COORD_BITS +: cbs_pkg::COORD_BITS];
    assign curve.d.x = s_tdata[6*cbs_pkg::COORD_BITS +: cbs_pkg::COORD_BITS];
    assign curve.d.y = s_tdata[7*cbs_pkg::COORD_BITS +: cbs_pkg::COORD_BITS];

    cbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .depth    (depth_sat),
        .status   (status),
        .cmd      (cmd)
    );

    cbs_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .curve    (curve),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .out_from (out_from),
        .out_to   (out_to),
        .out_last (m_tlast)
    );

    assign m_tdata = (8*cbs_pkg::OUT_BYTES)'({out_to.y, out_to.x, out_from.y, out_from.x});

endmodule

@@ tb/cubic_bezier_subdivider_top_tb.sv @@
`timescale 1ns / 100ps

module cubic_bezier_subdivider_top_tb;

    localparam int IN_DW      = 8 * cbs_pkg::IN_BYTES;
    localparam int OUT_DW     = 8 * cbs_pkg::OUT_BYTES;
    localparam int CYCLE_CAP  = 300000;
    localparam int N_RAND_SET = 12;
    localparam int SET_ITEMS  = 9;

    typedef struct packed {
        logic            last;
        cbs_pkg::coord_t to_y;
        cbs_pkg::coord_t to_x;
        cbs_pkg::coord_t from_y;
        cbs_pkg::coord_t from_x;
    } segment_t;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [IN_DW-1:0]  s_tdata     = '0;
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [OUT_DW-1:0] m_tdata;
    logic              m_tlast;
    logic              cfg_wr_en   = 1'b0;
    logic [cbs_pkg::DEPTH_W-1:0] cfg_wr_data = '0;

    logic [IN_DW-1:0] curves_pending[$];
    segment_t         segments_due[$];

    logic [cbs_pkg::DEPTH_W-1:0] depth_setting = 3'd4;
    cbs_pkg::coord_t pen_x, pen_y;
    int     seg_count, seg_total;

    int snd_idle_pct = 21;
    int rcv_idle_pct = 55;
    int errors = 0;
    int cycles = 0;

    cubic_bezier_subdivider_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // floor of the exact average
    function automatic cbs_pkg::coord_t half_sum(cbs_pkg::coord_t a, cbs_pkg::coord_t b);
        longint s;
        s = longint'(a) + longint'(b);
        return cbs_pkg::coord_t'(s >>> 1);
    endfunction

    task automatic emit_segment(input cbs_pkg::coord_t x, input cbs_pkg::coord_t y);
        segment_t seg;
        seg_count++;
        seg.from_x = pen_x;
        seg.from_y = pen_y;
        seg.to_x   = x;
        seg.to_y   = y;
        seg.last   = (seg_count == seg_total);
        segments_due.push_back(seg);
        pen_x = x;
        pen_y = y;
    endtask

    // depth-first halving; the pen is the first control point of each piece
    task automatic subdivide(input cbs_pkg::coord_t bx, input cbs_pkg::coord_t by,
                             input cbs_pkg::coord_t cx, input cbs_pkg::coord_t cy,
                             input cbs_pkg::coord_t dx, input cbs_pkg::coord_t dy,
                             input int lvl);
        cbs_pkg::coord_t abx, aby, bcx, bcy, cdx, cdy, abcx, abcy, bcdx, bcdy, mx, my;
        if (lvl == 0) begin
            emit_segment(bx, by);
            emit_segment(cx, cy);
            emit_segment(dx, dy);
        end else begin
            abx  = half_sum(pen_x, bx);
            aby  = half_sum(pen_y, by);
            bcx  = half_sum(bx, cx);
            bcy  = half_sum(by, cy);
            cdx  = half_sum(cx, dx);
            cdy  = half_sum(cy, dy);
            abcx = half_sum(abx, bcx);
            abcy = half_sum(aby, bcy);
            bcdx = half_sum(bcx, cdx);
            bcdy = half_sum(bcy, cdy);
            mx   = half_sum(abcx, bcdx);
            my   = half_sum(abcy, bcdy);
            subdivide(abx, aby, abcx, abcy, mx, my, lvl - 1);
            subdivide(bcdx, bcdy, cdx, cdy, dx, dy, lvl - 1);
        end
    endtask

    task automatic predict_segments(input logic [IN_DW-1:0] d);
        int lvl;
        lvl = (depth_setting > cbs_pkg::MAX_DEPTH) ? cbs_pkg::MAX_DEPTH :
              int'(depth_setting);
        seg_count = 0;
        seg_total = 3 << lvl;
        pen_x = d[23:0];
        pen_y = d[47:24];
        subdivide(d[71:48], d[95:72], d[119:96], d[143:120], d[167:144], d[191:168],
                  lvl);
    endtask

    task automatic queue_curve(input cbs_pkg::coord_t sx, input cbs_pkg::coord_t sy,
                               input cbs_pkg::coord_t ax, input cbs_pkg::coord_t ay,
                               input cbs_pkg::coord_t bx, input cbs_pkg::coord_t by,
                               input cbs_pkg::coord_t ex, input cbs_pkg::coord_t ey);
        curves_pending.push_back({ey, ex, by, bx, ay, ax, sy, sx});
    endtask

    // mostly uniform, sometimes pinned to a range end
    function automatic cbs_pkg::coord_t rand_coord();
        case ($urandom_range(7))
            0: return {1'b0, {(cbs_pkg::COORD_BITS-1){1'b1}}};
            1: return {1'b1, {(cbs_pkg::COORD_BITS-1){1'b0}}};
            default: return cbs_pkg::coord_t'($urandom);
        endcase
    endfunction

    task automatic queue_random_curves(input int n);
        repeat (n) begin
            queue_curve(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    // hold off until the block has nothing left in flight
    task automatic drain();
        do @(negedge aclk);
        while (curves_pending.size() != 0 || s_tvalid || segments_due.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_depth(input logic [cbs_pkg::DEPTH_W-1:0] d);
        drain();
        @(posedge aclk);
        cfg_wr_en     <= 1'b1;
        cfg_wr_data   <= d;
        depth_setting <= d;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
    endtask

    // source side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                predict_segments(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (curves_pending.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                    s_tdata  <= curves_pending.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink side and checking
    always @(posedge aclk) begin
        segment_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tlast, m_tdata[95:72], m_tdata[71:48], m_tdata[47:24],
                       m_tdata[23:0]};
                if (segments_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transaction: from (%0d,%0d) to (%0d,%0d) %s %0b",
                             $time, got.from_x, got.from_y, got.to_x, got.to_y, "last",
                             got.last);
                end else begin
                    want = segments_due.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: segment mismatch: expected from (%0d,%0d) to (%0d,%0d)",
                                 $time, want.from_x, want.from_y, want.to_x, want.to_y);
                        $display("%0t:                   expected last %0b", $time,
                                 want.last);
                        $display("%0t:                   actual from (%0d,%0d) to (%0d,%0d)",
                                 $time, got.from_x, got.from_y, got.to_x, got.to_y);
                        $display("%0t:                   actual last %0b", $time,
                                 got.last);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_CAP) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [cbs_pkg::DEPTH_W-1:0] rand_depths[N_RAND_SET];
        cbs_pkg::coord_t hi, lo;
        rand_depths = '{3'd2, 3'd4, 3'd1, 3'd3, 3'd0, 3'd4, 3'd3, 3'd5, 3'd2, 3'd4,
                        3'd1, 3'd7};
        hi = {1'b0, {(cbs_pkg::COORD_BITS-1){1'b1}}};
        lo = {1'b1, {(cbs_pkg::COORD_BITS-1){1'b0}}};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset depth of 4, range ends and odd sums that round toward minus infinity
        queue_curve(0, 0, 0, 0, 0, 0, 0, 0);
        queue_curve(hi, hi, hi, hi, hi, hi, hi, hi);
        queue_curve(lo, lo, lo, lo, lo, lo, lo, lo);
        queue_curve(hi, lo, lo, hi, hi, lo, lo, hi);
        queue_curve(lo, hi, hi, lo, lo, hi, hi, lo);
        queue_curve(1, -1, 0, 0, -1, 1, 3, -3);
        queue_curve(hi, hi, 0, 0, 0, 0, lo, lo);

        set_depth(3'd0);
        queue_curve(hi, hi, hi, hi, hi, hi, hi, hi);
        queue_curve(lo, lo, lo, lo, lo, lo, lo, lo);
        queue_curve(hi, lo, -1, 1, lo, hi, 5, -5);
        queue_random_curves(1);

        // depths above the limit behave as the limit
        set_depth(3'd7);
        queue_curve(hi, lo, lo, hi, -7, 7, lo, hi);
        queue_random_curves(1);
        set_depth(3'd5);
        queue_random_curves(1);
        set_depth(3'd6);
        queue_random_curves(1);
        set_depth(3'd1);
        queue_curve(-3, 3, 1, -1, hi, lo, lo, hi);

        for (int i = 0; i < N_RAND_SET; i++) begin
            set_depth(rand_depths[i]);
            case (i / 4)
                0: begin snd_idle_pct = 21; rcv_idle_pct = 55; end
                1: begin snd_idle_pct = 55; rcv_idle_pct = 21; end
                default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            queue_random_curves(SET_ITEMS);
        end

        drain();
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
